// ===== src/matrix_power_mod_prime_top_defines.svh =====
// assertion macros used by the checker file
`ifndef MATRIX_POWER_MOD_PRIME_TOP_DEFINES_SVH
`define MATRIX_POWER_MOD_PRIME_TOP_DEFINES_SVH

// clocked property, quiet while reset is asserted
`define MPMP_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define MPMP_NEVER(lbl, expr, msg) \
	`MPMP_PROP(lbl, !(expr), msg)

`endif

// ===== src/mpmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpmp_pkg
// Shared types and constants of the 2x2 matrix power modulo 1000000007.
// ----------------------------------------------------------------------------
package mpmp_pkg;

	localparam int ENTRY_W = 30;

	typedef logic [ENTRY_W-1:0] entry_t;
	// element 0 = row 0 col 0, 1 = row 0 col 1, 2 = row 1 col 0, 3 = row 1 col 1
	typedef logic [3:0][ENTRY_W-1:0] mat_t;

	localparam entry_t PRIME = 30'd1000000007;
	localparam logic [30:0] PRIME_X2 = 31'd2000000014;

	// barrett factor floor(2^62 / prime), fits in 33 bits
	localparam logic [63:0] BARRETT_WIDE = (64'd1 << 62) / 64'd1000000007;
	localparam logic [32:0] BARRETT_M = BARRETT_WIDE[32:0];

	// cycles from operands into a mac lane to its registered result
	localparam int MAC_LATENCY = 7;

	localparam mat_t MAT_IDENTITY = {30'd1, 30'd0, 30'd0, 30'd1};

	typedef struct packed {
		logic load;
		logic issue;
		logic sel_square;
		logic shift;
	} dp_cmd_t;

	typedef struct packed {
		logic exp_bit;
		logic pipe_busy;
	} dp_status_t;

endpackage

// ===== src/mpmp_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpmp_mac
// Pipelined lane computing (a*b + c*d) mod prime with barrett reduction.
// ----------------------------------------------------------------------------
module mpmp_mac import mpmp_pkg::*; (
	input  logic   clk,
	input  entry_t a,
	input  entry_t b,
	input  entry_t c,
	input  entry_t d,
	output entry_t res
);

	logic [59:0] m0_s1, m1_s1;
	logic [60:0] sum_s2, sum_s3, sum_s4;
	logic [64:0] prod_s3;
	logic [60:0] qp_s4;
	logic [31:0] r_s5;
	logic [30:0] r_s6;
	entry_t      res_s7;

	logic [30:0] q;
	logic [60:0] diff;

	// quotient estimate is at most two below the true one
	assign q    = prod_s3[63:33];
	assign diff = sum_s4 - qp_s4;

	always_ff @(posedge clk) begin
		m0_s1   <= 60'(a) * 60'(b);
		m1_s1   <= 60'(c) * 60'(d);
		sum_s2  <= 61'(m0_s1) + 61'(m1_s1);
		prod_s3 <= 65'(sum_s2[60:29]) * 65'(BARRETT_M);
		sum_s3  <= sum_s2;
		qp_s4   <= 61'(q) * 61'(PRIME);
		sum_s4  <= sum_s3;
		r_s5    <= diff[31:0];
		if (r_s5 >= 32'(PRIME_X2)) begin
			r_s6 <= 31'(r_s5 - 32'(PRIME_X2));
		end else begin
			r_s6 <= r_s5[30:0];
		end
		if (r_s6 >= 31'(PRIME)) begin
			res_s7 <= ENTRY_W'(r_s6 - 31'(PRIME));
		end else begin
			res_s7 <= r_s6[ENTRY_W-1:0];
		end
	end

	assign res = res_s7;

endmodule

// ===== src/mpmp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpmp_datapath
// Accumulator and square matrices, exponent shifter and four mac lanes.
// ----------------------------------------------------------------------------
module mpmp_datapath import mpmp_pkg::*; #(
	parameter int EXP_BITS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	input  entry_t      entry_00,
	input  entry_t      entry_01,
	input  entry_t      entry_10,
	input  entry_t      entry_11,
	input  logic [30:0] exponent,
	output mat_t        acc
);

	mat_t                  acc_q, sq_q;
	logic [EXP_BITS-1:0]   exp_q;
	logic [MAC_LATENCY-1:0] vld_q, dst_q;
	mat_t                  x, res;

	function automatic entry_t reduce_in(input entry_t e);
		if (e >= PRIME) begin
			return e - PRIME;
		end
		return e;
	endfunction

	assign x = cmd.sel_square ? sq_q : acc_q;

	for (genvar i = 0; i < 2; i++) begin : g_row
		for (genvar j = 0; j < 2; j++) begin : g_col
			mpmp_mac u_mac (
				.clk (clk),
				.a   (x[2*i]),
				.b   (sq_q[j]),
				.c   (x[2*i+1]),
				.d   (sq_q[2+j]),
				.res (res[2*i+j])
			);
		end
	end

	// tag pipe follows the lanes: which matrix the product goes back to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			dst_q <= '0;
		end else begin
			vld_q <= {vld_q[MAC_LATENCY-2:0], cmd.issue};
			dst_q <= {dst_q[MAC_LATENCY-2:0], cmd.sel_square};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= MAT_IDENTITY;
			sq_q  <= {reduce_in(entry_11), reduce_in(entry_10),
				reduce_in(entry_01), reduce_in(entry_00)};
			exp_q <= EXP_BITS'(exponent);
		end else begin
			if (cmd.shift) begin
				exp_q <= exp_q >> 1;
			end
			if (vld_q[MAC_LATENCY-1]) begin
				if (dst_q[MAC_LATENCY-1]) begin
					sq_q <= res;
				end else begin
					acc_q <= res;
				end
			end
		end
	end

	assign status.exp_bit   = exp_q[0];
	assign status.pipe_busy = |vld_q;
	assign acc              = acc_q;

endmodule

// ===== src/mpmp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpmp_ctrl
// Sequencer for square-and-multiply over the exponent bits.
// ----------------------------------------------------------------------------
module mpmp_ctrl import mpmp_pkg::*; #(
	parameter int EXP_BITS = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam int CNT_W = $clog2(EXP_BITS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SQR  = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!status.pipe_busy) begin
						state_q <= (cnt_q == CNT_W'(EXP_BITS)) ? ST_OUT : ST_MUL;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_MUL: begin
				// multiply into the accumulator only for a set bit
				cmd.issue = status.exp_bit;
			end
			ST_SQR: begin
				cmd.issue      = 1'b1;
				cmd.sel_square = 1'b1;
				cmd.shift      = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== src/matrix_power_mod_prime_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_power_mod_prime_top
// Raises a 2x2 matrix modulo 1000000007 to an unsigned power.
// ----------------------------------------------------------------------------
// One item at a time. Each of the EXP_BITS exponent bits costs a multiply
// issue, a square issue and a wait while the four pipelined mac lanes
// drain. The result is valid once all EXP_BITS bits are done, and the
// next item is taken in the cycle after the result leaves. The lane
// latency, set by the barrett reduction, governs how long each bit takes.
// Entries at or above the prime are reduced on entry; exponent bits at or
// above EXP_BITS are ignored.
module matrix_power_mod_prime_top import mpmp_pkg::*; #(
	parameter int EXP_BITS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [29:0] entry_00,
	input  logic [29:0] entry_01,
	input  logic [29:0] entry_10,
	input  logic [29:0] entry_11,
	input  logic [30:0] exponent,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [29:0] power_00,
	output logic [29:0] power_01,
	output logic [29:0] power_10,
	output logic [29:0] power_11
);

	dp_cmd_t    cmd;
	dp_status_t status;
	mat_t       acc;

	mpmp_ctrl #(.EXP_BITS(EXP_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mpmp_datapath #(.EXP_BITS(EXP_BITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.entry_00 (entry_00),
		.entry_01 (entry_01),
		.entry_10 (entry_10),
		.entry_11 (entry_11),
		.exponent (exponent),
		.acc      (acc)
	);

	assign power_00 = acc[0];
	assign power_01 = acc[1];
	assign power_10 = acc[2];
	assign power_11 = acc[3];

endmodule

// ===== src/mpmp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpmp_checker
// Port-level checks of the matrix power block, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix_power_mod_prime_top_defines.svh"

module mpmp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	`MPMP_PROP(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped before taken")
	`MPMP_NEVER(a_one_item, in_ready && out_valid, "new item taken while result pending")
	`MPMP_PROP(a_busy_after_in, in_valid && in_ready |=> !in_ready && !out_valid, "no work after item")
	`MPMP_PROP(a_idle_after_out, out_valid && out_ready |=> in_ready && !out_valid, "not idle after result")

endmodule

bind matrix_power_mod_prime_top mpmp_checker u_mpmp_checker (.*);

// ===== tb/matrix_power_mod_prime_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_power_mod_prime_top_tb
// Drives base matrices and exponents through the valid/ready input, predicts
// each 2x2 power modulo the prime by square-and-multiply and checks every
// result item in order, with random idling on both sides and a long output
// hold-off that backs up the input.
// ----------------------------------------------------------------------------
module matrix_power_mod_prime_top_tb;
	import mpmp_pkg::*;

	localparam int EXP_BITS = 31;
	localparam longint unsigned MODULUS = 64'd1000000007;
	localparam int RANDOM_ITEMS = 1400;
	localparam int QUIET_TAIL = 150;

	typedef struct {
		logic [29:0] m [4];
		logic [30:0] k;
	} job_t;

	typedef struct {
		logic [29:0] m [4];
	} power_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [29:0] entry_00, entry_01, entry_10, entry_11;
	logic [30:0] exponent;
	logic out_valid;
	logic out_ready;
	logic [29:0] power_00, power_01, power_10, power_11;

	job_t pending_jobs[$];
	power_t expected_powers[$];
	int mismatches = 0;
	int sent = 0;
	int total_jobs = 0;
	bit stim_done = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int holdoff = 0;
	bit holdoff_done = 0;

	matrix_power_mod_prime_top #(.EXP_BITS(EXP_BITS)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.entry_00(entry_00), .entry_01(entry_01),
		.entry_10(entry_10), .entry_11(entry_11),
		.exponent(exponent),
		.out_valid(out_valid), .out_ready(out_ready),
		.power_00(power_00), .power_01(power_01),
		.power_10(power_10), .power_11(power_11)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// 2x2 product, each entry a sum of two reduced products
	function automatic void mat_product(input longint unsigned a [4],
			input longint unsigned b [4], output longint unsigned r [4]);
		longint unsigned t;
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 2; j++) begin
				t = (a[2*i] * b[j]) % MODULUS;
				t = (t + (a[2*i+1] * b[2+j]) % MODULUS) % MODULUS;
				r[2*i+j] = t;
			end
		end
	endfunction

	function automatic power_t matrix_power(input job_t j);
		longint unsigned acc [4];
		longint unsigned sq [4];
		longint unsigned tmp [4];
		power_t p;
		for (int i = 0; i < 4; i++)
			sq[i] = longint'(j.m[i]) % MODULUS;
		acc = '{1, 0, 0, 1};
		for (int b = 0; b < EXP_BITS; b++) begin
			if (j.k[b]) begin
				mat_product(acc, sq, tmp);
				acc = tmp;
			end
			mat_product(sq, sq, tmp);
			sq = tmp;
		end
		for (int i = 0; i < 4; i++)
			p.m[i] = acc[i][29:0];
		return p;
	endfunction

	function automatic logic [29:0] rand_entry();
		case ($urandom_range(0, 9))
			0: return 30'($urandom_range(0, 3));
			1: return 30'(1000000007 - $urandom_range(1, 4));
			2: return 30'($urandom_range(1000000007, 1073741823));
			default: return 30'($urandom_range(0, 1000000006));
		endcase
	endfunction

	function automatic logic [30:0] rand_exponent();
		case ($urandom_range(0, 5))
			0: return 31'($urandom_range(0, 8));
			1: return 31'h7fffffff - 31'($urandom_range(0, 3));
			2: return 31'(1) << $urandom_range(0, 30);
			default: return 31'($urandom);
		endcase
	endfunction

	task automatic add_job(input logic [29:0] a, b, c, d, input logic [30:0] k);
		job_t j;
		j.m = '{a, b, c, d};
		j.k = k;
		pending_jobs.push_back(j);
	endtask

	initial begin
		job_t j;
		arst_n = 0;
		in_valid = 0;
		out_ready = 0;
		entry_00 = '0; entry_01 = '0; entry_10 = '0; entry_11 = '0;
		exponent = '0;
		// directed: identity at exponent zero, field extremes, unreduced entries
		add_job(30'd5, 30'd7, 30'd11, 30'd13, 31'd0);
		add_job(30'h3fffffff, 30'h3fffffff, 30'h3fffffff, 30'h3fffffff, 31'd0);
		add_job(30'd1, 30'd1, 30'd1, 30'd0, 31'd1);
		add_job(30'd1, 30'd1, 30'd1, 30'd0, 31'd10);
		add_job(30'd1, 30'd1, 30'd1, 30'd0, 31'h7fffffff);
		add_job(30'd0, 30'd0, 30'd0, 30'd0, 31'd0);
		add_job(30'd0, 30'd0, 30'd0, 30'd0, 31'd3);
		add_job(30'd1000000006, 30'd1000000006, 30'd1000000006, 30'd1000000006,
			31'h7fffffff);
		add_job(30'd1000000007, 30'd1000000008, 30'h3fffffff, 30'd1000000006, 31'd2);
		add_job(30'h3fffffff, 30'h3fffffff, 30'h3fffffff, 30'h3fffffff, 31'h7fffffff);
		add_job(30'h2aaaaaaa, 30'h15555555, 30'h15555555, 30'h2aaaaaaa, 31'h55555555);
		add_job(30'h15555555, 30'h2aaaaaaa, 30'h2aaaaaaa, 30'h15555555, 31'h2aaaaaaa);
		add_job(30'd2, 30'd0, 30'd0, 30'd3, 31'h40000000);
		add_job(30'd123456789, 30'd987654321, 30'd1, 30'd2, 31'd1000000006);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			j.m = '{rand_entry(), rand_entry(), rand_entry(), rand_entry()};
			j.k = rand_exponent();
			pending_jobs.push_back(j);
		end
		total_jobs = pending_jobs.size();
		stim_done = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1;
	end

	// sender
	always @(posedge clk) begin
		job_t j;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				j.m = '{entry_00, entry_01, entry_10, entry_11};
				j.k = exponent;
				expected_powers.push_back(matrix_power(j));
				sent++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 0;
				end else if (pending_jobs.size() > 0) begin
					j = pending_jobs.pop_front();
					entry_00 <= j.m[0]; entry_01 <= j.m[1];
					entry_10 <= j.m[2]; entry_11 <= j.m[3];
					exponent <= j.k;
					in_valid <= 1;
					if (pending_jobs.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 18);
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// long output hold-off once, early on, so the input backs up
	always @(posedge clk) begin
		if (arst_n && !holdoff_done && sent >= 20) begin
			holdoff++;
			if (holdoff >= 2000)
				holdoff_done <= 1;
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		power_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_powers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result item %h %h %h %h",
							power_00, power_01, power_10, power_11);
				end else begin
					want = expected_powers.pop_front();
					if (want.m[0] !== power_00 || want.m[1] !== power_01 ||
							want.m[2] !== power_10 || want.m[3] !== power_11) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
								want.m[0], want.m[1], want.m[2], want.m[3],
								power_00, power_01, power_10, power_11);
					end
				end
			end
			if (sent >= 20 && !holdoff_done) begin
				out_ready <= 0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
				if (pending_jobs.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
					recv_gap = $urandom_range(1, 18);
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (arst_n);
		wait (pending_jobs.size() == 0 && sent == total_jobs &&
			expected_powers.size() == 0);
		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("matrix_power_mod_prime_top test passed");
		else
			$display("matrix_power_mod_prime_top test failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("matrix_power_mod_prime_top test failed");
		$finish;
	end

endmodule
